// ----- rtl/core/tns_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_pkg
// Shared widths, codes and defaults of the nearest-neighbour texture sampler.
// ----------------------------------------------------------------------------
package tns_pkg;

   localparam int COORD_W      = 32;  // signed fixed-point u, v
   localparam int ADDR_FIELD_W = 16;  // texel index carried by a load
   localparam int RGB_W        = 24;
   localparam int CH_W         = 8;
   localparam int SIZE_W       = 11;  // width / height registers
   localparam int IDX_W        = 2 * SIZE_W;
   localparam int CSR_IDX_W    = 2;

   localparam int DEF_MAX_TEXELS = 65536;
   localparam int DEF_FRAC_BITS  = 16;

   localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;

   typedef enum logic {
      ACTION_LOAD   = 1'b0,
      ACTION_SAMPLE = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEX_WIDTH  = 2'd0,
      CSR_TEX_HEIGHT = 2'd1,
      CSR_WRAP_X     = 2'd2,
      CSR_WRAP_Y     = 2'd3
   } csr_index_type;

   typedef enum logic {
      WRAP_REPEAT = 1'b0,
      WRAP_CLAMP  = 1'b1
   } wrap_type;

endpackage

// ----- rtl/core/tns_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tns_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tns_axis_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_axis_map
// Two-stage map of one coordinate to a texel position: wrap or clamp into
// 0..1 (optionally mirrored to 1-c), then scale by the span and round half up.
// ----------------------------------------------------------------------------
module tns_axis_map
   import tns_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic signed [COORD_W-1:0] coord,
   input  logic                      clamp,
   input  logic                      invert,
   input  logic [SIZE_W-1:0]         span,
   output logic [SIZE_W-1:0]         pos
);

   localparam int C_W    = FRAC_BITS + 1;
   localparam int PROD_W = SIZE_W + C_W;
   localparam logic [COORD_W-1:0] ONE_COORD = COORD_W'(1) << FRAC_BITS;
   localparam logic [C_W-1:0]     ONE_C     = C_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0]  HALF_P    = PROD_W'(1) << (FRAC_BITS - 1);

   logic             in_unit;
   logic [C_W-1:0]   wrapped;
   logic [C_W-1:0]   unit_in;
   logic [C_W-1:0]   unit_ff;
   logic [PROD_W-1:0] scaled;
   logic [SIZE_W-1:0] pos_ff;

   // stage a: bring into 0..1
   always_comb begin
      in_unit = !coord[COORD_W-1] && (coord <= ONE_COORD);
      if (in_unit) begin
         wrapped = coord[C_W-1:0];
      end else if (clamp == WRAP_CLAMP) begin
         wrapped = coord[COORD_W-1] ? '0 : ONE_C;
      end else begin
         wrapped = {1'b0, coord[FRAC_BITS-1:0]};
      end
      unit_in = invert ? (ONE_C - wrapped) : wrapped;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         unit_ff <= unit_in;
      end
   end

   // stage b: span * c + half, keep the integer part
   assign scaled = (PROD_W'(span) * PROD_W'(unit_ff)) + HALF_P;

   always_ff @(posedge clock) begin
      if (enable) begin
         pos_ff <= scaled[FRAC_BITS +: SIZE_W];
      end
   end

   assign pos = pos_ff;

endmodule

// ----- rtl/core/texture_nearest_sampler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_nearest_sampler_unit
// Nearest-neighbour texture sampler with a private RGB888 texel memory.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the pipeline stalls. A sample transfer
// passes wrap, scale, row index and memory read, each one register stage,
// and an output register follows. Loads travel
// the same stages and write the texel memory at the index stage, so a sample
// accepted after a load always sees it. The memory has one write and one
// read port; it is not cleared, and a texel must be loaded before it is
// sampled. The pipeline stalls only when a result sits in the read stage and
// the output register is still held, so input is taken while a result waits.
// Configuration is one register per transfer and is always ready.
// ----------------------------------------------------------------------------
module texture_nearest_sampler_unit
   import tns_pkg::*;
#(
   parameter int MAX_TEXELS = DEF_MAX_TEXELS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // item channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  logic [ADDR_FIELD_W-1:0]   req_texel_addr,
   input  logic [RGB_W-1:0]          req_texel_rgb,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [CH_W-1:0]           rsp_red,
   output logic [CH_W-1:0]           rsp_green,
   output logic [CH_W-1:0]           rsp_blue,
   output logic [CH_W-1:0]           rsp_alpha,
   // register port
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [SIZE_W-1:0]         csr_wdata
);

   localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
   localparam logic [31:0] MAX_TEXELS_W = 32'(MAX_TEXELS);

   // configuration
   logic [SIZE_W-1:0] tex_width_ff;
   logic [SIZE_W-1:0] tex_height_ff;
   logic              wrap_x_ff;
   logic              wrap_y_ff;
   logic [SIZE_W-1:0] width_eff;
   logic [SIZE_W-1:0] height_eff;
   logic [SIZE_W-1:0] span_x;
   logic [SIZE_W-1:0] span_y;

   // pipeline control
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_sample_ff, s2_sample_ff, s3_sample_ff;
   logic s4_valid_in;

   // load payload carried to the index stage
   logic [ADDR_FIELD_W-1:0] s1_addr_ff, s2_addr_ff, s3_addr_ff;
   logic [RGB_W-1:0]        s1_rgb_ff, s2_rgb_ff, s3_rgb_ff;

   // sample path
   logic [SIZE_W-1:0] pos_x;
   logic [SIZE_W-1:0] pos_y;
   logic [IDX_W-1:0]  idx_in;
   logic [IDX_W-1:0]  s3_idx_ff;
   logic              s4_in_range_ff;
   logic [RGB_W-1:0]  ram_rdata;
   logic              ram_we;

   // output register
   logic             rsp_valid_ff;
   logic [RGB_W-1:0] rsp_rgb_ff;

   // -------------------------------------------------------------------------
   // configuration registers
   // -------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= SIZE_W'(1);
         tex_height_ff <= SIZE_W'(1);
         wrap_x_ff     <= WRAP_REPEAT;
         wrap_y_ff     <= WRAP_REPEAT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TEX_WIDTH:  tex_width_ff  <= csr_wdata;
            CSR_TEX_HEIGHT: tex_height_ff <= csr_wdata;
            CSR_WRAP_X:     wrap_x_ff     <= csr_wdata[0];
            CSR_WRAP_Y:     wrap_y_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // a size of zero counts as one
   assign width_eff  = (tex_width_ff == '0) ? SIZE_W'(1) : tex_width_ff;
   assign height_eff = (tex_height_ff == '0) ? SIZE_W'(1) : tex_height_ff;
   assign span_x     = width_eff - SIZE_W'(1);
   assign span_y     = height_eff - SIZE_W'(1);

   // -------------------------------------------------------------------------
   // pipeline control
   // -------------------------------------------------------------------------
   assign advance   = !(s4_valid_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;
   assign s4_valid_in = s3_valid_ff && s3_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sample_ff <= (req_action == ACTION_SAMPLE);
         s2_sample_ff <= s1_sample_ff;
         s3_sample_ff <= s2_sample_ff;
         s1_addr_ff   <= req_texel_addr;
         s2_addr_ff   <= s1_addr_ff;
         s3_addr_ff   <= s2_addr_ff;
         s1_rgb_ff    <= req_texel_rgb;
         s2_rgb_ff    <= s1_rgb_ff;
         s3_rgb_ff    <= s2_rgb_ff;
      end
   end

   // -------------------------------------------------------------------------
   // coordinate mapping: stages 1 and 2
   // -------------------------------------------------------------------------
   tns_axis_map #(
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_x (
      .clock  (clock),
      .enable (advance),
      .coord  (req_u_coord),
      .clamp  (wrap_x_ff),
      .invert (1'b0),
      .span   (span_x),
      .pos    (pos_x)
   );

   // image rows run top down, v runs bottom up
   tns_axis_map #(
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_y (
      .clock  (clock),
      .enable (advance),
      .coord  (req_v_coord),
      .clamp  (wrap_y_ff),
      .invert (1'b1),
      .span   (span_y),
      .pos    (pos_y)
   );

   // -------------------------------------------------------------------------
   // stage 3: row-major index
   // -------------------------------------------------------------------------
   assign idx_in = IDX_W'(pos_x) + (IDX_W'(pos_y) * IDX_W'(width_eff));

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_idx_ff <= idx_in;
      end
   end

   // -------------------------------------------------------------------------
   // stage 4: texel memory
   // -------------------------------------------------------------------------
   assign ram_we = advance && s3_valid_ff && !s3_sample_ff
                   && (32'(s3_addr_ff) < MAX_TEXELS_W);

   tns_ram #(
      .WIDTH (RGB_W),
      .DEPTH (MAX_TEXELS)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(s3_addr_ff)),
      .wr_data (s3_rgb_ff),
      .rd_en   (advance),
      .rd_addr (AW'(s3_idx_ff)),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_in_range_ff <= (32'(s3_idx_ff) < MAX_TEXELS_W);
      end
   end

   // -------------------------------------------------------------------------
   // output register
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s4_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // a read past the store gives black
   always_ff @(posedge clock) begin
      if (advance && s4_valid_ff) begin
         rsp_rgb_ff <= s4_in_range_ff ? ram_rdata : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_rgb_ff[2*CH_W +: CH_W];
   assign rsp_green = rsp_rgb_ff[CH_W +: CH_W];
   assign rsp_blue  = rsp_rgb_ff[0 +: CH_W];
   assign rsp_alpha = ALPHA_FULL;

endmodule

// ----- rtl/core/tns_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_checker
// Port-level checks of the texture sampler, bound to the top level.
// ----------------------------------------------------------------------------
module tns_checker
   import tns_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [CH_W-1:0] rsp_red,
   input logic [CH_W-1:0] rsp_green,
   input logic [CH_W-1:0] rsp_blue,
   input logic [CH_W-1:0] rsp_alpha
);

   // a held result keeps its texel
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("result changed before its transfer");

   // input only backs up behind a held result
   a_ready_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with the result side free");

   // nothing left over from before reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_alpha_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alpha == ALPHA_FULL)
      else $error("alpha not full");

endmodule

bind texture_nearest_sampler_unit tns_checker u_tns_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for texture_nearest_sampler_unit. A short table of
// directed loads, samples and register writes comes first, then random
// phases under random texture sizes and wrap modes. Each sample is predicted
// from a local copy of the texel memory and registers or set by the table, and
// a texel is always loaded before any sample that reads it. Results are
// checked channel by channel in order, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb
   import tns_pkg::*;
();

   localparam longint ONE_FX  = longint'(1) << DEF_FRAC_BITS;
   localparam longint HALF_FX = longint'(1) << (DEF_FRAC_BITS - 1);

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
   } pixel_type;

   typedef enum logic {ROW_REG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      csr_index_type             reg_idx;
      logic [SIZE_W-1:0]         reg_val;
      action_type                act;
      logic [ADDR_FIELD_W-1:0]   addr;
      logic [RGB_W-1:0]          rgb;
      logic signed [COORD_W-1:0] u;
      logic signed [COORD_W-1:0] v;
      bit                        typed;
      logic [RGB_W-1:0]          want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   action_type                req_action     = ACTION_LOAD;
   logic [ADDR_FIELD_W-1:0]   req_texel_addr = '0;
   logic [RGB_W-1:0]          req_texel_rgb  = '0;
   logic signed [COORD_W-1:0] req_u_coord    = '0;
   logic signed [COORD_W-1:0] req_v_coord    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic [CH_W-1:0]           rsp_red;
   logic [CH_W-1:0]           rsp_green;
   logic [CH_W-1:0]           rsp_blue;
   logic [CH_W-1:0]           rsp_alpha;
   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index      = CSR_TEX_WIDTH;
   logic [SIZE_W-1:0]         csr_wdata      = '0;

   // local copy of the block state
   logic [RGB_W-1:0]  model_texels [DEF_MAX_TEXELS];
   bit                model_loaded [DEF_MAX_TEXELS];
   logic [SIZE_W-1:0] cfg_width  = SIZE_W'(1);
   logic [SIZE_W-1:0] cfg_height = SIZE_W'(1);
   wrap_type          cfg_wrap_x = WRAP_REPEAT;
   wrap_type          cfg_wrap_y = WRAP_REPEAT;

   pixel_type   pixel_queue [$];
   dir_row_type dir_table [$];
   int          mismatches  = 0;
   int          burst_left  = 0;
   int          holds_asked = 0;
   int          holds_done  = 0;

   texture_nearest_sampler_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_texel_addr (req_texel_addr),
      .req_texel_rgb  (req_texel_rgb),
      .req_u_coord    (req_u_coord),
      .req_v_coord    (req_v_coord),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic longint wrap_axis(longint c, wrap_type mode);
      if (c >= 0 && c <= ONE_FX)
         return c;
      if (mode == WRAP_CLAMP)
         return (c < 0) ? 0 : ONE_FX;
      return c & (ONE_FX - 1);
   endfunction

   function automatic longint round_scaled(longint span, longint c);
      return (span * c + HALF_FX) >> DEF_FRAC_BITS;
   endfunction

   // row-major texel index hit by a sample under the current registers
   function automatic longint texel_index(logic signed [COORD_W-1:0] u,
                                          logic signed [COORD_W-1:0] v);
      longint w, h, xi, yi;
      w  = (cfg_width == '0) ? longint'(1) : longint'(cfg_width);
      h  = (cfg_height == '0) ? longint'(1) : longint'(cfg_height);
      xi = round_scaled(w - 1, wrap_axis(u, cfg_wrap_x));
      yi = round_scaled(h - 1, ONE_FX - wrap_axis(v, cfg_wrap_y));
      return xi + yi * w;
   endfunction

   function automatic dir_row_type reg_row(csr_index_type idx,
                                           logic [SIZE_W-1:0] val);
      dir_row_type r;
      r.kind    = ROW_REG;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   function automatic dir_row_type load_row(logic [ADDR_FIELD_W-1:0] addr,
                                            logic [RGB_W-1:0] rgb);
      dir_row_type r;
      r.kind  = ROW_ITEM;
      r.act   = ACTION_LOAD;
      r.addr  = addr;
      r.rgb   = rgb;
      r.u     = '1;  // ignored by a load
      r.v     = '1;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic dir_row_type samp_row(logic signed [COORD_W-1:0] u,
                                            logic signed [COORD_W-1:0] v,
                                            bit typed, logic [RGB_W-1:0] want);
      dir_row_type r;
      r.kind  = ROW_ITEM;
      r.act   = ACTION_SAMPLE;
      r.u     = u;
      r.v     = v;
      r.typed = typed;
      r.want  = want;
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0: return SIZE_W'(0);
         1: return SIZE_W'(1);
         2: return SIZE_W'(1024);
         3: return SIZE_W'(2047);
         4, 5: return SIZE_W'($urandom_range(2, 8));
         default: return SIZE_W'($urandom_range(1, 2047));
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) << DEF_FRAC_BITS;           // exact edges
         2: return ($urandom_range(0, 8) - 4) << DEF_FRAC_BITS;     // whole numbers
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         4: return 32'h2000 * $urandom_range(1, 7);                 // rounding ties
         5: return $urandom | 32'h8000_0000;                        // negative
         default: return $urandom_range(0, 32'h1_0000);
      endcase
   endfunction

   // one transfer on the item channel, sent in bursts with random gaps
   task automatic offer(action_type act, logic [ADDR_FIELD_W-1:0] addr,
                        logic [RGB_W-1:0] rgb, logic signed [COORD_W-1:0] u,
                        logic signed [COORD_W-1:0] v, bit typed,
                        logic [RGB_W-1:0] want);
      int        gap;
      longint    idx;
      pixel_type px;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid      = 1'b1;
      req_action     = act;
      req_texel_addr = addr;
      req_texel_rgb  = rgb;
      req_u_coord    = u;
      req_v_coord    = v;
      do @(posedge clock); while (req_ready !== 1'b1);
      burst_left--;
      if (act == ACTION_LOAD) begin
         model_texels[addr] = rgb;
         model_loaded[addr] = 1'b1;
      end else begin
         idx = texel_index(u, v);
         if (typed)
            px = {want, ALPHA_FULL};
         else if (idx < DEF_MAX_TEXELS)
            px = {model_texels[idx], ALPHA_FULL};
         else
            px = {{RGB_W{1'b0}}, ALPHA_FULL};
         pixel_queue.push_back(px);
      end
   endtask

   // a texel is loaded first wherever the sample would read an empty entry
   task automatic sample_at(logic signed [COORD_W-1:0] u,
                            logic signed [COORD_W-1:0] v, bit typed,
                            logic [RGB_W-1:0] want);
      longint idx;
      idx = texel_index(u, v);
      if (idx < DEF_MAX_TEXELS && !model_loaded[idx])
         offer(ACTION_LOAD, idx[ADDR_FIELD_W-1:0], RGB_W'($urandom),
               COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
      offer(ACTION_SAMPLE, ADDR_FIELD_W'($urandom), RGB_W'($urandom), u, v,
            typed, want);
   endtask

   // loads leave nothing to wait for, so allow the pipeline depth on top
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [SIZE_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_TEX_WIDTH:  cfg_width  = val;
         CSR_TEX_HEIGHT: cfg_height = val;
         CSR_WRAP_X:     cfg_wrap_x = wrap_type'(val[0]);
         CSR_WRAP_Y:     cfg_wrap_y = wrap_type'(val[0]);
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic check_channel(string chan, logic [CH_W-1:0] want,
                                logic [CH_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s expected %02h, got %02h", $time, chan, want, got);
      end
   endtask

   // result side: own stall pattern, plus a long hold-off when asked
   initial begin
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            rsp_ready = 1'b0;
            repeat (120) @(negedge clock);
            holds_done++;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(10, 60);
         end
         left--;
         case (mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            2: rsp_ready = ($urandom_range(0, 3) == 0);
            default: rsp_ready = ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            mismatches++;
            $display("%0t ns: expected no result, got %02h %02h %02h %02h", $time,
                     rsp_red, rsp_green, rsp_blue, rsp_alpha);
         end else begin
            want = pixel_queue.pop_front();
            check_channel("red", want.red, rsp_red);
            check_channel("green", want.green, rsp_green);
            check_channel("blue", want.blue, rsp_blue);
            check_channel("alpha", want.alpha, rsp_alpha);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb failed");
      $finish;
   end

   initial begin
      int phase;
      int n;
      // 1x1 texture after reset: every coordinate lands on texel 0
      dir_table.push_back(load_row(16'h0000, 24'hFF_FFFF));
      dir_table.push_back(samp_row(32'h0000_0000, 32'h0000_0000, 1'b1, 24'hFF_FFFF));
      dir_table.push_back(load_row(16'h0000, 24'h00_0000));
      dir_table.push_back(samp_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 24'h00_0000));
      dir_table.push_back(load_row(16'h0000, 24'h5A_3CC3));
      dir_table.push_back(samp_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 24'h5A_3CC3));
      // 3x2, repeat on both axes
      dir_table.push_back(reg_row(CSR_TEX_WIDTH, SIZE_W'(3)));
      dir_table.push_back(reg_row(CSR_TEX_HEIGHT, SIZE_W'(2)));
      dir_table.push_back(reg_row(CSR_WRAP_X, SIZE_W'(WRAP_REPEAT)));
      dir_table.push_back(reg_row(CSR_WRAP_Y, SIZE_W'(WRAP_REPEAT)));
      dir_table.push_back(samp_row(32'h0000_4000, 32'h0000_0000, 1'b0, '0)); // tie
      dir_table.push_back(samp_row(32'h0001_0000, 32'h0001_0000, 1'b0, '0));
      dir_table.push_back(samp_row(32'h0002_0000, 32'hFFFF_0000, 1'b0, '0));
      dir_table.push_back(samp_row(32'hFFFF_8000, 32'h0001_8000, 1'b0, '0));
      // clamp to edge
      dir_table.push_back(reg_row(CSR_WRAP_X, SIZE_W'(WRAP_CLAMP)));
      dir_table.push_back(reg_row(CSR_WRAP_Y, SIZE_W'(WRAP_CLAMP)));
      dir_table.push_back(samp_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0));
      dir_table.push_back(samp_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0));
      // zero size behaves as one
      dir_table.push_back(reg_row(CSR_TEX_WIDTH, SIZE_W'(0)));
      dir_table.push_back(reg_row(CSR_TEX_HEIGHT, SIZE_W'(0)));
      dir_table.push_back(samp_row(32'h0001_2345, 32'hFFFF_FFFF, 1'b0, '0));
      // oversized texture: far corner lies past the store and reads black
      dir_table.push_back(reg_row(CSR_TEX_WIDTH, SIZE_W'(2047)));
      dir_table.push_back(reg_row(CSR_TEX_HEIGHT, SIZE_W'(2047)));
      dir_table.push_back(samp_row(32'h0001_0000, 32'h0000_0000, 1'b1, 24'h00_0000));
      dir_table.push_back(samp_row(32'h0000_0000, 32'h0001_0000, 1'b0, '0));
      dir_table.push_back(samp_row(32'h0000_0100, 32'h0001_0000, 1'b0, '0));
      dir_table.push_back(reg_row(CSR_TEX_WIDTH, SIZE_W'(1024)));
      dir_table.push_back(reg_row(CSR_TEX_HEIGHT, SIZE_W'(1024)));
      dir_table.push_back(samp_row(32'h0001_0000, 32'h0000_0000, 1'b0, '0));
      dir_table.push_back(samp_row(32'h0001_0000, 32'h0000_FC00, 1'b0, '0));

      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_REG) begin
            wait_idle();
            write_csr(dir_table[i].reg_idx, dir_table[i].reg_val);
         end else if (dir_table[i].act == ACTION_LOAD) begin
            offer(ACTION_LOAD, dir_table[i].addr, dir_table[i].rgb,
                  dir_table[i].u, dir_table[i].v, 1'b0, '0);
         end else begin
            sample_at(dir_table[i].u, dir_table[i].v, dir_table[i].typed,
                      dir_table[i].want);
         end
      end

      for (phase = 0; phase < 8; phase++) begin
         wait_idle();
         write_csr(CSR_TEX_WIDTH, pick_size());
         write_csr(CSR_TEX_HEIGHT, pick_size());
         write_csr(CSR_WRAP_X, SIZE_W'($urandom_range(0, 1)));
         write_csr(CSR_WRAP_Y, SIZE_W'($urandom_range(0, 1)));
         for (n = 0; n < 25; n++) begin
            // long result hold-off while input keeps coming
            if (phase == 2 && n == 5)
               holds_asked++;
            if (phase == 5 && n == 12)
               wait_idle();
            if ($urandom_range(0, 9) == 0)
               offer(ACTION_LOAD, ADDR_FIELD_W'($urandom), RGB_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
            else
               sample_at(pick_coord(), pick_coord(), 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatches == 0 && pixel_queue.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
